/* sv/lfdc_pkg.sv */
// lfdc_pkg: shared types and constants of the line-follow drive controller
// operation codes, register indexes, reset values and the result record
// no dependencies
package lfdc_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    // configuration port layout
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN_POWER   = 3'd4;

    // fixed field widths
    localparam int THRESH_W = 12;
    localparam int STEP_W   = 15;
    localparam int POWER_W  = 16;
    localparam int TICKS_W  = 23;
    localparam int COUNT_W  = 8;

    // register reset values
    localparam logic [THRESH_W-1:0]       RST_SENSOR_THRESHOLD = 12'd2000;
    localparam logic [STEP_W-1:0]         RST_ACCEL_STEP       = 15'd66;
    localparam logic [STEP_W-1:0]         RST_START_SPEED      = 15'd4915;
    localparam logic [TICKS_W-1:0]        RST_SLOWDOWN_TICKS   = 23'd450;
    localparam logic signed [POWER_W-1:0] RST_SLOWDOWN_POWER   = 16'sd8192;

    // driving states
    localparam logic [1:0] LINE_ON        = 2'd0;
    localparam logic [1:0] LINE_OFF_LEFT  = 2'd1;
    localparam logic [1:0] LINE_OFF_RIGHT = 2'd2;

    // station counting sensor select
    localparam logic [1:0] SEL_LEFT        = 2'd0;
    localparam logic [1:0] SEL_RIGHT       = 2'd1;
    localparam logic [1:0] SEL_FRONT_LEFT  = 2'd2;
    localparam logic [1:0] SEL_FRONT_RIGHT = 2'd3;

    // saturation limits of a Q2.14 power word
    localparam logic signed [POWER_W-1:0] POWER_MIN = 16'sh8000;
    localparam logic signed [POWER_W-1:0] POWER_MAX = 16'sh7FFF;

    // one result item
    typedef struct packed {
        logic                      drive_update;
        logic signed [POWER_W-1:0] forward_drive;
        logic signed [POWER_W-1:0] steer_drive;
        logic                      zero_encoders;
        logic                      station_reached;
        logic [1:0]                line_position;
        logic                      following;
    } result_t;

endpackage

/* sv/lfdc_item_if.sv */
// lfdc_item_if: input item channel of the line-follow drive controller
// valid/ready handshake with the item fields; widths of samples and encoders
// follow the ADC_BITS and ENC_BITS parameters
interface lfdc_item_if #(
    parameter int ADC_BITS = 12,
    parameter int ENC_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic signed [15:0]         leg_power;
    logic signed [15:0]         turn_power_in;
    logic [22:0]                leg_ticks;
    logic [ADC_BITS-1:0]        front_left_sample;
    logic [ADC_BITS-1:0]        front_right_sample;
    logic [ADC_BITS-1:0]        left_sample;
    logic [ADC_BITS-1:0]        right_sample;
    logic signed [ENC_BITS-1:0] left_encoder;
    logic signed [ENC_BITS-1:0] right_encoder;
    logic [1:0]                 station_side;
    logic [7:0]                 tape_count;

    modport source (
        output valid, op, leg_power, turn_power_in, leg_ticks,
        output front_left_sample, front_right_sample, left_sample, right_sample,
        output left_encoder, right_encoder, station_side, tape_count,
        input  ready
    );

    modport sink (
        input  valid, op, leg_power, turn_power_in, leg_ticks,
        input  front_left_sample, front_right_sample, left_sample, right_sample,
        input  left_encoder, right_encoder, station_side, tape_count,
        output ready
    );
endinterface

/* sv/lfdc_result_if.sv */
// lfdc_result_if: result channel of the line-follow drive controller
// valid/ready handshake with the drive command fields
// no dependencies
interface lfdc_result_if;
    logic               valid;
    logic               ready;
    logic               drive_update;
    logic signed [15:0] forward_drive;
    logic signed [15:0] steer_drive;
    logic               zero_encoders;
    logic               station_reached;
    logic [1:0]         line_position;
    logic               following;

    modport source (
        output valid, drive_update, forward_drive, steer_drive,
        output zero_encoders, station_reached, line_position, following,
        input  ready
    );

    modport sink (
        input  valid, drive_update, forward_drive, steer_drive,
        input  zero_encoders, station_reached, line_position, following,
        output ready
    );
endinterface

/* sv/lfdc_cfg_if.sv */
// lfdc_cfg_if: configuration write channel of the line-follow drive controller
// valid/ready handshake carrying a register index and write data
// depends on lfdc_pkg for the index and data widths
interface lfdc_cfg_if
    import lfdc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/line_follow_drive_controller.sv */
// line_follow_drive_controller: top level of the line-follow drive controller
// control state, configuration registers and a two-deep result buffer
// depends on lfdc_pkg, lfdc_item_if, lfdc_result_if and lfdc_cfg_if
//
// usage
//   item_in    : one item per transfer; op selects start leg, tick, station
//                poll or stop. all work for an item is done in the cycle of
//                its transfer, the control state updates at that edge.
//   result_out : exactly one result per item, in order. each result is
//                registered in the output register, or in the skid register.
//   cfg        : register writes, always ready; write only while idle.
//   throughput : one item per cycle while the skid is empty, set by the single
//                pass through the threshold, clamp and counter logic into the control state.
//   stall      : a result register plus a one-entry skid register; while the
//                receiver stalls, one more item is taken into the skid, then
//                item_in.ready drops until the receiver takes a result.
//   reset      : rst_n clears the control state to not following, on line,
//                powers zero, counter idle and armed, and loads the register
//                defaults. no clearing pass, items are taken right after reset.
module line_follow_drive_controller
    import lfdc_pkg::*;
#(
    parameter int ADC_BITS = 12,
    parameter int ENC_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    lfdc_item_if.sink     item_in,
    lfdc_result_if.source result_out,
    lfdc_cfg_if.sink      cfg
);

    // compare widths
    localparam int SW = (ADC_BITS > THRESH_W) ? ADC_BITS : THRESH_W;
    localparam int CW = ((ENC_BITS > TICKS_W + 2) ? ENC_BITS : TICKS_W + 2) + 1;
    localparam int PW = POWER_W + 2;

    // configuration registers
    logic [THRESH_W-1:0]       threshold_reg;
    logic [STEP_W-1:0]         accel_step_reg;
    logic [STEP_W-1:0]         start_speed_reg;
    logic [TICKS_W-1:0]        slowdown_ticks_reg;
    logic signed [POWER_W-1:0] slowdown_power_reg;

    // control state
    logic                      follow_reg, follow_next;
    logic [1:0]                line_state_reg, line_state_next;
    logic signed [POWER_W-1:0] target_power_reg, target_power_next;
    logic signed [POWER_W-1:0] current_power_reg, current_power_next;
    logic signed [POWER_W-1:0] turn_power_reg, turn_power_next;
    logic [TICKS_W-1:0]        leg_limit_reg, leg_limit_next;
    logic                      slow_armed_reg, slow_armed_next;
    logic                      station_busy_reg, station_busy_next;
    logic [COUNT_W-1:0]        crossings_reg, crossings_next;
    logic [1:0]                sensor_sel_reg, sensor_sel_next;
    logic                      count_armed_reg, count_armed_next;

    // result buffer
    result_t out_reg, skid_reg, result;
    logic    out_valid_reg, skid_valid_reg;

    logic accept, take;

    // datapath helpers
    logic                      on_fl, on_fr, on_l, on_r, on_sel;
    logic [1:0]                poll_sel;
    logic signed [ENC_BITS-1:0] enc_min;
    logic signed [CW-1:0]      slow_bound;
    logic                      slow_hit;
    logic signed [PW-1:0]      cur_w, step_w, lo_w, hi_w, tgt_w;
    logic signed [PW-1:0]      fp_w, ss_w;
    logic signed [POWER_W-1:0] neg_turn;

    assign accept = item_in.valid && item_in.ready;
    assign take   = result_out.valid && result_out.ready;

    assign item_in.ready = !skid_valid_reg;
    assign cfg.ready     = 1'b1;

    // tape detection, strictly above threshold
    assign on_fl = SW'(item_in.front_left_sample) > SW'(threshold_reg);
    assign on_fr = SW'(item_in.front_right_sample) > SW'(threshold_reg);
    assign on_l  = SW'(item_in.left_sample) > SW'(threshold_reg);
    assign on_r  = SW'(item_in.right_sample) > SW'(threshold_reg);

    // slow-down distance test in wide signed arithmetic
    assign enc_min    = (item_in.left_encoder < item_in.right_encoder) ?
                        item_in.left_encoder : item_in.right_encoder;
    assign slow_bound = $signed(CW'(leg_limit_reg)) - $signed(CW'(slowdown_ticks_reg));
    assign slow_hit   = slow_armed_reg && (CW'(enc_min) > slow_bound);

    // start-leg clamp operands
    assign fp_w = PW'(item_in.leg_power);
    assign ss_w = $signed(PW'(start_speed_reg));

    // slew window around the current power, target after a slow-down hit
    assign cur_w  = PW'(current_power_reg);
    assign step_w = $signed(PW'(accel_step_reg));
    assign lo_w   = cur_w - step_w;
    assign hi_w   = cur_w + step_w;
    assign tgt_w  = slow_hit ? PW'(slowdown_power_reg) : PW'(target_power_reg);

    // saturating negation of the turn power
    assign neg_turn = (turn_power_reg == POWER_MIN) ? POWER_MAX : -turn_power_reg;

    // station sensor chosen by the selection in force for this poll
    assign poll_sel = station_busy_reg ? sensor_sel_reg : item_in.station_side;

    always_comb
    begin
        unique case (poll_sel)
            SEL_LEFT:        on_sel = on_l;
            SEL_RIGHT:       on_sel = on_r;
            SEL_FRONT_LEFT:  on_sel = on_fl;
            SEL_FRONT_RIGHT: on_sel = on_fr;
            default:         on_sel = on_fr;
        endcase
    end

    // next control state and result of the accepted item
    always_comb
    begin
        follow_next        = follow_reg;
        line_state_next    = line_state_reg;
        target_power_next  = target_power_reg;
        current_power_next = current_power_reg;
        turn_power_next    = turn_power_reg;
        leg_limit_next     = leg_limit_reg;
        slow_armed_next    = slow_armed_reg;
        station_busy_next  = station_busy_reg;
        crossings_next     = crossings_reg;
        sensor_sel_next    = sensor_sel_reg;
        count_armed_next   = count_armed_reg;
        result             = '0;

        // poll start latches the count and sensor before the sample is read
        if (accept && item_in.op == OP_POLL && !station_busy_reg)
        begin
            count_armed_next  = 1'b1;
            station_busy_next = 1'b1;
            crossings_next    = item_in.tape_count;
            sensor_sel_next   = item_in.station_side;
        end

        if (accept)
        begin
            unique case (item_in.op)
                OP_START:
                begin
                    slow_armed_next   = 1'b1;
                    target_power_next = item_in.leg_power;
                    if (fp_w < -ss_w)
                        current_power_next = POWER_W'(-ss_w);
                    else if (fp_w > ss_w)
                        current_power_next = POWER_W'(ss_w);
                    else
                        current_power_next = item_in.leg_power;
                    turn_power_next      = item_in.turn_power_in;
                    follow_next          = 1'b1;
                    leg_limit_next       = item_in.leg_ticks;
                    result.zero_encoders = 1'b1;
                end
                OP_TICK:
                begin
                    if (slow_hit)
                    begin
                        target_power_next = slowdown_power_reg;
                        slow_armed_next   = 1'b0;
                    end
                    // slew toward target, never past it
                    if (tgt_w < lo_w)
                        current_power_next = POWER_W'(lo_w);
                    else if (tgt_w > hi_w)
                        current_power_next = POWER_W'(hi_w);
                    else
                        current_power_next = target_power_next;
                    // both fronts off keeps the last state
                    priority if (on_fl && on_fr)
                        line_state_next = LINE_ON;
                    else if (on_fr)
                        line_state_next = LINE_OFF_LEFT;
                    else if (on_fl)
                        line_state_next = LINE_OFF_RIGHT;
                    else
                        line_state_next = line_state_reg;
                    if (follow_reg)
                    begin
                        result.drive_update  = 1'b1;
                        result.forward_drive = current_power_next;
                        if (line_state_next == LINE_OFF_LEFT)
                            result.steer_drive = turn_power_reg;
                        else if (line_state_next == LINE_OFF_RIGHT)
                            result.steer_drive = neg_turn;
                        else
                            result.steer_drive = '0;
                    end
                end
                OP_POLL:
                begin
                    // count one rising crossing, floor at zero
                    if (on_sel && count_armed_next)
                    begin
                        if (crossings_next != '0)
                            crossings_next = crossings_next - COUNT_W'(1);
                        count_armed_next = 1'b0;
                    end
                    if (crossings_next == '0)
                    begin
                        station_busy_next      = 1'b0;
                        follow_next            = 1'b0;
                        result.drive_update    = 1'b1;
                        result.station_reached = 1'b1;
                    end
                    else if (!on_sel && !count_armed_next)
                    begin
                        count_armed_next = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    follow_next         = 1'b0;
                    result.drive_update = 1'b1;
                end
                default:
                begin
                    follow_next = follow_reg;
                end
            endcase
        end

        result.line_position = line_state_next;
        result.following     = follow_next;
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_reg        <= 1'b0;
            line_state_reg    <= LINE_ON;
            target_power_reg  <= '0;
            current_power_reg <= '0;
            turn_power_reg    <= '0;
            leg_limit_reg     <= '0;
            slow_armed_reg    <= 1'b0;
            station_busy_reg  <= 1'b0;
            crossings_reg     <= '0;
            sensor_sel_reg    <= SEL_LEFT;
            count_armed_reg   <= 1'b1;
        end
        else
        begin
            follow_reg        <= follow_next;
            line_state_reg    <= line_state_next;
            target_power_reg  <= target_power_next;
            current_power_reg <= current_power_next;
            turn_power_reg    <= turn_power_next;
            leg_limit_reg     <= leg_limit_next;
            slow_armed_reg    <= slow_armed_next;
            station_busy_reg  <= station_busy_next;
            crossings_reg     <= crossings_next;
            sensor_sel_reg    <= sensor_sel_next;
            count_armed_reg   <= count_armed_next;
        end
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= RST_SENSOR_THRESHOLD;
            accel_step_reg     <= RST_ACCEL_STEP;
            start_speed_reg    <= RST_START_SPEED;
            slowdown_ticks_reg <= RST_SLOWDOWN_TICKS;
            slowdown_power_reg <= RST_SLOWDOWN_POWER;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SENSOR_THRESHOLD: threshold_reg      <= cfg.data[THRESH_W-1:0];
                REG_ACCEL_STEP:       accel_step_reg     <= cfg.data[STEP_W-1:0];
                REG_START_SPEED:      start_speed_reg    <= cfg.data[STEP_W-1:0];
                REG_SLOWDOWN_TICKS:   slowdown_ticks_reg <= cfg.data[TICKS_W-1:0];
                REG_SLOWDOWN_POWER:   slowdown_power_reg <= $signed(cfg.data[POWER_W-1:0]);
                default:              threshold_reg      <= threshold_reg;
            endcase
        end
    end

    // result buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (take)
                    skid_valid_reg <= 1'b0;
            end
            else if (accept && out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            if (accept || skid_valid_reg)
                out_valid_reg <= 1'b1;
            else if (take)
                out_valid_reg <= 1'b0;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

    // result channel outputs
    assign result_out.valid           = out_valid_reg;
    assign result_out.drive_update    = out_reg.drive_update;
    assign result_out.forward_drive   = out_reg.forward_drive;
    assign result_out.steer_drive     = out_reg.steer_drive;
    assign result_out.zero_encoders   = out_reg.zero_encoders;
    assign result_out.station_reached = out_reg.station_reached;
    assign result_out.line_position   = out_reg.line_position;
    assign result_out.following       = out_reg.following;

    // skid entry only exists behind a held result
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid entry without a result in the output register");

    // a busy station count is never at zero
    a_busy_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        station_busy_reg |-> (crossings_reg != '0)
    ) else $error("station count busy at zero");

    // a reached station ends following
    a_reached_stops: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && result.station_reached) |=> (!follow_reg && !station_busy_reg)
    ) else $error("station reached but still following or busy");

    // start leg arms following and the slow-down
    a_start_arms: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && item_in.op == OP_START) |=> (follow_reg && slow_armed_reg)
    ) else $error("start leg did not arm following");

    // results without a drive command carry zero drive
    a_idle_zero_drive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.drive_update) |->
            (out_reg.forward_drive == '0 && out_reg.steer_drive == '0)
    ) else $error("drive values without a drive command");

endmodule

/* sim/lfdc_tb_pkg.sv */
// lfdc_tb_pkg: input item record and drive command scoreboard for the controller bench
// the scoreboard predicts every result from accepted items and register writes
// depends on lfdc_pkg for op codes, register indexes and the result record
package lfdc_tb_pkg;
    import lfdc_pkg::*;

    // one input item as seen on the item channel
    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] leg_power;
        logic signed [15:0] turn_power_in;
        logic [22:0]        leg_ticks;
        logic [11:0]        front_left_sample;
        logic [11:0]        front_right_sample;
        logic [11:0]        left_sample;
        logic [11:0]        right_sample;
        logic signed [23:0] left_encoder;
        logic signed [23:0] right_encoder;
        logic [1:0]         station_side;
        logic [7:0]         tape_count;
    } ctrl_item_t;

    class drive_cmd_scoreboard;
        // register copies
        logic [11:0]        threshold;
        logic [14:0]        accel;
        logic [14:0]        start_clamp;
        logic [22:0]        slow_dist;
        logic signed [15:0] slow_power;

        // control state
        bit         follow_on;
        logic [1:0] line_st;
        int         target_pwr;
        int         current_pwr;
        int         turn_pwr;
        int         leg_len;
        bit         slow_pending;
        bit         station_on;
        int         tapes_left;
        logic [1:0] count_sel;
        bit         count_ready;

        // drive commands still owed by the block, oldest first
        result_t expected_cmds[$];
        int      mismatches;

        function new();
            threshold    = RST_SENSOR_THRESHOLD;
            accel        = RST_ACCEL_STEP;
            start_clamp  = RST_START_SPEED;
            slow_dist    = RST_SLOWDOWN_TICKS;
            slow_power   = RST_SLOWDOWN_POWER;
            follow_on    = 1'b0;
            line_st      = LINE_ON;
            target_pwr   = 0;
            current_pwr  = 0;
            turn_pwr     = 0;
            leg_len      = 0;
            slow_pending = 1'b0;
            station_on   = 1'b0;
            tapes_left   = 0;
            count_sel    = SEL_LEFT;
            count_ready  = 1'b1;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SENSOR_THRESHOLD: threshold   = data[11:0];
                REG_ACCEL_STEP:       accel       = data[14:0];
                REG_START_SPEED:      start_clamp = data[14:0];
                REG_SLOWDOWN_TICKS:   slow_dist   = data[22:0];
                REG_SLOWDOWN_POWER:   slow_power  = data[15:0];
                default: ;
            endcase
        endfunction

        function bit on_tape(logic [11:0] sample);
            return sample > threshold;
        endfunction

        // predict the drive command of one accepted item
        function void note_item(ctrl_item_t it);
            result_t     r;
            longint      near_end;
            longint      bound;
            bit          fl;
            bit          fr;
            bit          on;
            logic [11:0] sample;
            int          lim;
            int          lo;
            int          hi;
            int          steer;
            r = '0;
            case (it.op)
                OP_START:
                begin
                    lim          = int'(start_clamp);
                    slow_pending = 1'b1;
                    target_pwr   = int'(it.leg_power);
                    current_pwr  = (target_pwr < -lim) ? -lim :
                                   (target_pwr > lim) ? lim : target_pwr;
                    turn_pwr     = int'(it.turn_power_in);
                    follow_on    = 1'b1;
                    leg_len      = int'(it.leg_ticks);
                    r.zero_encoders = 1'b1;
                end
                OP_TICK:
                begin
                    near_end = (it.left_encoder < it.right_encoder) ?
                               longint'(it.left_encoder) : longint'(it.right_encoder);
                    fl = on_tape(it.front_left_sample);
                    fr = on_tape(it.front_right_sample);
                    // one-shot slow-down, compared without wrap
                    bound = longint'(leg_len) - longint'(slow_dist);
                    if (slow_pending && near_end > bound)
                    begin
                        target_pwr   = int'(slow_power);
                        slow_pending = 1'b0;
                    end
                    // slew toward target by at most one step
                    lo = current_pwr - int'(accel);
                    hi = current_pwr + int'(accel);
                    current_pwr = (target_pwr < lo) ? lo : (target_pwr > hi) ? hi : target_pwr;
                    if (!fl && fr) line_st = LINE_OFF_LEFT;
                    if (!fr && fl) line_st = LINE_OFF_RIGHT;
                    if (fl && fr)  line_st = LINE_ON;
                    if (follow_on)
                    begin
                        r.drive_update  = 1'b1;
                        r.forward_drive = 16'(current_pwr);
                        if (line_st == LINE_OFF_LEFT)
                            steer = turn_pwr;
                        else if (line_st == LINE_OFF_RIGHT)
                            steer = (turn_pwr == -32768) ? 32767 : -turn_pwr;
                        else
                            steer = 0;
                        r.steer_drive = 16'(steer);
                    end
                end
                OP_POLL:
                begin
                    if (!station_on)
                    begin
                        count_ready = 1'b1;
                        station_on  = 1'b1;
                        tapes_left  = int'(it.tape_count);
                        count_sel   = it.station_side;
                    end
                    case (count_sel)
                        SEL_LEFT:       sample = it.left_sample;
                        SEL_RIGHT:      sample = it.right_sample;
                        SEL_FRONT_LEFT: sample = it.front_left_sample;
                        default:        sample = it.front_right_sample;
                    endcase
                    on = on_tape(sample);
                    // count rising crossings only, never below zero
                    if (on && count_ready)
                    begin
                        if (tapes_left != 0) tapes_left--;
                        count_ready = 1'b0;
                    end
                    if (tapes_left == 0)
                    begin
                        station_on        = 1'b0;
                        follow_on         = 1'b0;
                        r.drive_update    = 1'b1;
                        r.station_reached = 1'b1;
                    end
                    else if (!on && !count_ready)
                    begin
                        count_ready = 1'b1;
                    end
                end
                default:
                begin
                    follow_on      = 1'b0;
                    r.drive_update = 1'b1;
                end
            endcase
            r.line_position = line_st;
            r.following     = follow_on;
            expected_cmds.push_back(r);
        endfunction

        // print every field of one drive command
        function void show_cmd(string tag, result_t v);
            $display("%s upd=%0d fwd=%0d steer=%0d zero=%0d reach=%0d pos=%0d fol=%0d", tag,
                     v.drive_update, v.forward_drive, v.steer_drive, v.zero_encoders,
                     v.station_reached, v.line_position, v.following);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_command(result_t got);
            result_t want;
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    show_cmd("unexpected result with nothing pending:", got);
                return;
            end
            want = expected_cmds.pop_front();
            if (got.drive_update !== want.drive_update ||
                got.forward_drive !== want.forward_drive ||
                got.steer_drive !== want.steer_drive ||
                got.zero_encoders !== want.zero_encoders ||
                got.station_reached !== want.station_reached ||
                got.line_position !== want.line_position ||
                got.following !== want.following)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    show_cmd("mismatch expected", want);
                    show_cmd("         actual  ", got);
                end
            end
        endfunction
    endclass

endpackage

/* sim/tb_line_follow_drive_controller.sv */
// tb_line_follow_drive_controller: self-checking bench of the line-follow drive controller
// directed items, then random legs, station polls and noise under several register settings
// depends on lfdc_pkg, the three channel interfaces, lfdc_tb_pkg and the controller
module tb_line_follow_drive_controller
    import lfdc_pkg::*;
    import lfdc_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lfdc_item_if #(.ADC_BITS(12), .ENC_BITS(24)) item_bus ();
    lfdc_result_if result_bus ();
    lfdc_cfg_if cfg_bus ();

    line_follow_drive_controller #(.ADC_BITS(12), .ENC_BITS(24)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus),
        .cfg        (cfg_bus)
    );

    drive_cmd_scoreboard sb;
    int         items_sent = 0;
    int         burst_left = 0;
    result_t    seen_result;
    ctrl_item_t seen_item;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run time limit
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // observe transfers on every channel at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen_result.drive_update    = result_bus.drive_update;
                seen_result.forward_drive   = result_bus.forward_drive;
                seen_result.steer_drive     = result_bus.steer_drive;
                seen_result.zero_encoders   = result_bus.zero_encoders;
                seen_result.station_reached = result_bus.station_reached;
                seen_result.line_position   = result_bus.line_position;
                seen_result.following       = result_bus.following;
                sb.check_command(seen_result);
            end
            if (item_bus.valid && item_bus.ready)
            begin
                seen_item.op                 = item_bus.op;
                seen_item.leg_power          = item_bus.leg_power;
                seen_item.turn_power_in      = item_bus.turn_power_in;
                seen_item.leg_ticks          = item_bus.leg_ticks;
                seen_item.front_left_sample  = item_bus.front_left_sample;
                seen_item.front_right_sample = item_bus.front_right_sample;
                seen_item.left_sample        = item_bus.left_sample;
                seen_item.right_sample       = item_bus.right_sample;
                seen_item.left_encoder       = item_bus.left_encoder;
                seen_item.right_encoder      = item_bus.right_encoder;
                seen_item.station_side       = item_bus.station_side;
                seen_item.tape_count         = item_bus.tape_count;
                sb.note_item(seen_item);
            end
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(cfg_bus.index, cfg_bus.data);
        end
    end

    // receiver stalls on a rotating 16-bit mask, rerolled now and then
    initial
    begin : receiver
        logic [15:0] stall_mask;
        int          slot;
        slot = 0;
        result_bus.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            repeat ($urandom_range(16, 96))
            begin
                @(negedge clk);
                result_bus.ready = stall_mask[slot];
                slot = (slot + 1) % 16;
            end
        end
    end

    function automatic ctrl_item_t op_item(logic [1:0] op);
        ctrl_item_t it;
        it.op                 = op;
        it.leg_power          = '0;
        it.turn_power_in      = '0;
        it.leg_ticks          = '0;
        it.front_left_sample  = '0;
        it.front_right_sample = '0;
        it.left_sample        = '0;
        it.right_sample       = '0;
        it.left_encoder       = '0;
        it.right_encoder      = '0;
        it.station_side       = SEL_LEFT;
        it.tape_count         = '0;
        return it;
    endfunction

    function automatic ctrl_item_t rand_item();
        ctrl_item_t it;
        it.op                 = 2'($urandom);
        it.leg_power          = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.turn_power_in      = 16'(int'($urandom_range(0, 32768)) - 16384);
        it.leg_ticks          = 23'($urandom);
        it.front_left_sample  = 12'($urandom);
        it.front_right_sample = 12'($urandom);
        it.left_sample        = 12'($urandom);
        it.right_sample       = 12'($urandom);
        it.left_encoder       = 24'($urandom);
        it.right_encoder      = 24'($urandom);
        it.station_side       = 2'($urandom);
        it.tape_count         = 8'($urandom_range(1, 255));
        return it;
    endfunction

    // sample on or off tape for the current threshold, often right at the edge
    function automatic logic [11:0] rand_sample(bit on);
        int thr;
        thr = int'(sb.threshold);
        if (on && thr < 4095)
            return ($urandom_range(0, 3) == 0) ? 12'(thr + 1) : 12'($urandom_range(thr + 1, 4095));
        if (!on)
            return ($urandom_range(0, 3) == 0) ? 12'(thr) : 12'($urandom_range(0, thr));
        return 12'($urandom);
    endfunction

    // one item transfer; the sender works in bursts with random gaps
    task automatic drive_item(ctrl_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                item_bus.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        item_bus.valid              = 1'b1;
        item_bus.op                 = it.op;
        item_bus.leg_power          = it.leg_power;
        item_bus.turn_power_in      = it.turn_power_in;
        item_bus.leg_ticks          = it.leg_ticks;
        item_bus.front_left_sample  = it.front_left_sample;
        item_bus.front_right_sample = it.front_right_sample;
        item_bus.left_sample        = it.left_sample;
        item_bus.right_sample       = it.right_sample;
        item_bus.left_encoder       = it.left_encoder;
        item_bus.right_encoder      = it.right_encoder;
        item_bus.station_side       = it.station_side;
        item_bus.tape_count         = it.tape_count;
        do @(posedge clk); while (!item_bus.ready);
        items_sent++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // low extreme, high extreme, reset value or random
    function automatic int pick_value(int phase, int lo, int hi, int dflt);
        int mode;
        mode = (phase == 1) ? 0 : (phase == 2) ? 1 : $urandom_range(0, 3);
        case (mode)
            0:       return lo;
            1:       return hi;
            2:       return dflt;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // registers change only once the block has drained
    task automatic apply_settings(int phase);
        @(negedge clk);
        item_bus.valid = 1'b0;
        burst_left = 0;
        while (sb.expected_cmds.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write(REG_SENSOR_THRESHOLD, pick_value(phase, 0, 4095, 2000));
        cfg_write(REG_ACCEL_STEP, pick_value(phase, 0, 16384, 66));
        cfg_write(REG_START_SPEED, pick_value(phase, 0, 16384, 4915));
        cfg_write(REG_SLOWDOWN_TICKS, pick_value(phase, 0, 8388607, 450));
        cfg_write(REG_SLOWDOWN_POWER, pick_value(phase, 0, 32768, 8192 + 16384) - 16384);
    endtask

    // a station poll run: the chosen sensor goes on and off tape
    task automatic run_station();
        ctrl_item_t  it;
        logic [1:0]  side;
        int          tapes;
        bit          on;
        side  = 2'($urandom);
        tapes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        on    = 1'b0;
        repeat (2 * tapes + $urandom_range(0, 3))
        begin
            if ($urandom_range(0, 1) == 1) on = !on;
            it = rand_item();
            it.op                 = OP_POLL;
            it.station_side       = side;
            it.tape_count         = 8'(tapes);
            it.left_sample        = rand_sample(1'($urandom_range(0, 1)));
            it.right_sample       = rand_sample(1'($urandom_range(0, 1)));
            it.front_left_sample  = rand_sample(1'($urandom_range(0, 1)));
            it.front_right_sample = rand_sample(1'($urandom_range(0, 1)));
            case (side)
                SEL_LEFT:       it.left_sample        = rand_sample(on);
                SEL_RIGHT:      it.right_sample       = rand_sample(on);
                SEL_FRONT_LEFT: it.front_left_sample  = rand_sample(on);
                default:        it.front_right_sample = rand_sample(on);
            endcase
            drive_item(it);
        end
    endtask

    // one leg: start, ticks with encoders running toward the leg end, maybe a stop
    task automatic run_leg();
        ctrl_item_t it;
        int pos;
        int len;
        int ticks;
        int stride;
        int pick;
        it = rand_item();
        it.op = OP_START;
        if ($urandom_range(0, 3) != 0) it.leg_ticks = 23'($urandom_range(0, 3000));
        len = int'(it.leg_ticks);
        drive_item(it);
        pos    = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 200)) : 0;
        ticks  = $urandom_range(10, 60);
        stride = len / ticks * 2 + 20;
        repeat (ticks)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                run_station();
            end
            else if (pick == 1)
            begin
                drive_item(rand_item());
            end
            else
            begin
                it = rand_item();
                it.op = OP_TICK;
                pos += $urandom_range(0, stride);
                it.left_encoder  = 24'(pos + $urandom_range(0, 10) - 5);
                it.right_encoder = 24'(pos + $urandom_range(0, 10) - 5);
                pick = $urandom_range(0, 9);
                it.front_left_sample  = rand_sample(pick < 7);
                it.front_right_sample = rand_sample(pick < 5 || pick == 7 || pick == 8);
                drive_item(it);
            end
        end
        if ($urandom_range(0, 1) == 1) drive_item(op_item(OP_STOP));
    endtask

    // main sequence
    initial
    begin : stimulus
        ctrl_item_t it;
        int         quota;
        int         pick;
        sb = new();
        item_bus.valid = 1'b0;
        item_bus.op = OP_STOP;
        item_bus.leg_power = '0;
        item_bus.turn_power_in = '0;
        item_bus.leg_ticks = '0;
        item_bus.front_left_sample = '0;
        item_bus.front_right_sample = '0;
        item_bus.left_sample = '0;
        item_bus.right_sample = '0;
        item_bus.left_encoder = '0;
        item_bus.right_encoder = '0;
        item_bus.station_side = SEL_LEFT;
        item_bus.tape_count = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_SENSOR_THRESHOLD;
        cfg_bus.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick while not following: state moves, no command
        it = op_item(OP_TICK);
        it.front_left_sample = 12'd4095;
        drive_item(it);
        // poll asking for zero crossings reports at once
        it = op_item(OP_POLL);
        it.tape_count = 8'd0;
        drive_item(it);
        // start above the clamp, turn at the most negative value
        it = op_item(OP_START);
        it.leg_power = 16'sd16384;
        it.turn_power_in = POWER_MIN;
        it.leg_ticks = 23'd0;
        drive_item(it);
        // off right: negated turn saturates; encoders at both extremes
        it = op_item(OP_TICK);
        it.front_left_sample = 12'd4095;
        it.left_encoder = 24'sh800000;
        it.right_encoder = 24'sh7FFFFF;
        drive_item(it);
        // off left, slow-down test lands exactly on the limit
        it = op_item(OP_TICK);
        it.front_right_sample = 12'd4095;
        it.left_encoder = -24'sd450;
        it.right_encoder = 24'sd100;
        drive_item(it);
        // both front sensors at threshold count as off: state held, slow-down fires
        it = op_item(OP_TICK);
        it.front_left_sample = 12'd2000;
        it.front_right_sample = 12'd2000;
        it.left_encoder = -24'sd449;
        drive_item(it);
        it = op_item(OP_TICK);
        it.front_left_sample = 12'd4095;
        it.front_right_sample = 12'd4095;
        it.left_encoder = 24'sh7FFFFF;
        it.right_encoder = 24'sh7FFFFF;
        drive_item(it);
        drive_item(op_item(OP_STOP));
        // longest leg, reverse power of -16384
        it = op_item(OP_START);
        it.leg_power = -16'sd16384;
        it.turn_power_in = 16'sd16384;
        it.leg_ticks = 23'd8388607;
        drive_item(it);
        it = op_item(OP_TICK);
        it.front_left_sample = 12'd2001;
        it.left_encoder = 24'sh7FFFFF;
        it.right_encoder = 24'sh7FFFFF;
        drive_item(it);
        it = op_item(OP_TICK);
        it.front_right_sample = 12'd4095;
        drive_item(it);
        // two crossings on front right, held on tape, then off and on again
        it = op_item(OP_POLL);
        it.station_side = SEL_FRONT_RIGHT;
        it.tape_count = 8'd2;
        it.front_right_sample = 12'd4095;
        drive_item(it);
        drive_item(it);
        it.front_right_sample = 12'd0;
        drive_item(it);
        it.front_right_sample = 12'd2001;
        drive_item(it);
        drive_item(op_item(OP_TICK));
        it = op_item(OP_START);
        it.leg_ticks = 23'd450;
        drive_item(it);
        // counting latches its sensor; later side and count are ignored
        it = op_item(OP_POLL);
        it.station_side = SEL_RIGHT;
        it.tape_count = 8'd255;
        it.right_sample = 12'd4095;
        drive_item(it);
        it = op_item(OP_POLL);
        it.station_side = SEL_FRONT_LEFT;
        it.tape_count = 8'd1;
        it.front_left_sample = 12'd4095;
        drive_item(it);
        drive_item(op_item(OP_STOP));
        it = op_item(OP_POLL);
        it.station_side = SEL_LEFT;
        it.tape_count = 8'd3;
        it.right_sample = 12'd4095;
        drive_item(it);
        it = op_item(OP_TICK);
        it.left_encoder = 24'sd450;
        it.right_encoder = 24'sd450;
        drive_item(it);

        // random part over several register settings
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase != 0) apply_settings(phase);
            quota = items_sent + 210;
            while (items_sent < quota)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    run_leg();
                end
                else if (pick < 85)
                begin
                    run_station();
                end
                else
                begin
                    repeat ($urandom_range(1, 6)) drive_item(rand_item());
                end
            end
        end

        // drain and settle
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (sb.expected_cmds.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_cmds.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/lfdc_pkg.sv
sv/lfdc_item_if.sv
sv/lfdc_result_if.sv
sv/lfdc_cfg_if.sv
sv/line_follow_drive_controller.sv
sim/lfdc_tb_pkg.sv
sim/tb_line_follow_drive_controller.sv
